// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl files
// each macro expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: invariant");

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next cycle");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// stt_pkg
// types and constants shared by the token scanner and its channel interfaces
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stt_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int LEN_WIDTH  = 16;
    localparam int LEAD_BYTES = 6;
    localparam int LEAD_WIDTH = 8 * LEAD_BYTES;

    localparam logic [LEN_WIDTH-1:0] LEN_MAX = '1;

    typedef enum logic [4:0] {
        TOK_INVALID = 5'd0,
        TOK_EOF     = 5'd1,
        TOK_IDENT   = 5'd2,
        TOK_INT     = 5'd3,
        TOK_PLUS    = 5'd4,
        TOK_MINUS   = 5'd5,
        TOK_STAR    = 5'd6,
        TOK_SLASH   = 5'd7,
        TOK_ASSIGN  = 5'd8,
        TOK_AMP     = 5'd9,
        TOK_LPAREN  = 5'd10,
        TOK_RPAREN  = 5'd11,
        TOK_LBRACE  = 5'd12,
        TOK_RBRACE  = 5'd13,
        TOK_SEMI    = 5'd14,
        TOK_RETURN  = 5'd15,
        TOK_IF      = 5'd16,
        TOK_ELSE    = 5'd17,
        TOK_FOR     = 5'd18
    } tok_kind_t;

    typedef enum logic [1:0] {
        CAUSE_NONE       = 2'd0,
        CAUSE_NUM_LETTER = 2'd1,
        CAUSE_STRAY      = 2'd2
    } err_cause_t;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'b001,
        MODE_NUM   = 3'b010,
        MODE_IDENT = 3'b100
    } scan_mode_t;

    // keyword text, first character in the low byte
    localparam logic [LEAD_WIDTH-1:0] TXT_RETURN = LEAD_WIDTH'("nruter");
    localparam logic [LEAD_WIDTH-1:0] TXT_IF     = LEAD_WIDTH'("fi");
    localparam logic [LEAD_WIDTH-1:0] TXT_ELSE   = LEAD_WIDTH'("esle");
    localparam logic [LEAD_WIDTH-1:0] TXT_FOR    = LEAD_WIDTH'("rof");

    typedef struct packed {
        tok_kind_t         kind;
        logic [31:0]       start;
        logic [15:0]       length;
        err_cause_t        cause;
        logic              last;
    } token_t;

endpackage

// ===== rtl/core/stt_byte_if.sv =====
// ----------------------------------------------------------------------------
// stt_byte_if
// valid/ready channel carrying one source byte per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink   (input valid, input char_byte, output ready);
endinterface

// ===== rtl/core/stt_token_if.sv =====
// ----------------------------------------------------------------------------
// stt_token_if
// valid/ready channel carrying one scanned token per item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface stt_token_if;
    logic                  valid;
    logic                  ready;
    stt_pkg::tok_kind_t    token_kind;
    logic [31:0]           token_start;
    logic [15:0]           token_length;
    stt_pkg::err_cause_t   error_cause;
    logic                  last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output error_cause, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input error_cause, input last_of_run,
                    output ready);
endinterface

// ===== rtl/core/source_token_scanner.sv =====
// ----------------------------------------------------------------------------
// source_token_scanner
// streaming lexer: bytes in, tokens (kind, start, length, cause) out
// ----------------------------------------------------------------------------
//  channel | direction | item
//  chars   | in        | char_byte
//  tokens  | out       | token_kind, token_start, token_length, error_cause,
//          |           | last_of_run
//
//  one byte is taken per cycle while the result buffer has room; scan state
//  updates in the accepting cycle and the byte's tokens land in a two-entry result
//  buffer the next cycle; a byte that closes a token and yields its own token
//  gives two results, and the buffer then holds off the next byte while they drain
//  chars.ready depends on tokens.ready in the same cycle when one result waits
//  reset clears scan state, position and the result buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module source_token_scanner (
    input  logic          clk,
    input  logic          rst_n,
    stt_byte_if.sink      chars,
    stt_token_if.source   tokens
);

    localparam int PW = stt_pkg::POS_WIDTH;
    localparam int LW = stt_pkg::LEN_WIDTH;
    localparam int DW = stt_pkg::LEAD_WIDTH;

    stt_pkg::scan_mode_t mode_reg, mode_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW-1:0]       run_start_reg, run_start_next;
    logic [LW-1:0]       run_len_reg, run_len_next;
    logic                has_letter_reg, has_letter_next;
    logic [DW-1:0]       lead_reg, lead_next;

    stt_pkg::token_t     slot0_reg, slot0_next;
    stt_pkg::token_t     slot1_reg, slot1_next;
    logic [1:0]          cnt_reg, cnt_next;

    stt_pkg::token_t     res0, res1, run_tok, byte_tok;
    logic [1:0]          n_res;
    logic                in_acc, out_acc;
    logic [7:0]          c;
    logic                c_digit, c_alpha, c_space, in_run;
    stt_pkg::tok_kind_t  op_k;

    function automatic stt_pkg::tok_kind_t ident_kind(
        input logic [DW-1:0] lead,
        input logic [LW-1:0] len
    );
        stt_pkg::tok_kind_t k;
        k = stt_pkg::TOK_IDENT;
        if (len == LW'(6) && lead == stt_pkg::TXT_RETURN)
            k = stt_pkg::TOK_RETURN;
        else if (len == LW'(2) && lead == stt_pkg::TXT_IF)
            k = stt_pkg::TOK_IF;
        else if (len == LW'(4) && lead == stt_pkg::TXT_ELSE)
            k = stt_pkg::TOK_ELSE;
        else if (len == LW'(3) && lead == stt_pkg::TXT_FOR)
            k = stt_pkg::TOK_FOR;
        return k;
    endfunction

    assign c       = chars.char_byte;
    assign in_acc  = chars.valid && chars.ready;
    assign out_acc = tokens.valid && tokens.ready;

    assign c_digit = (c >= "0") && (c <= "9");
    assign c_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
    assign c_space = (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    assign in_run  = (mode_reg == stt_pkg::MODE_NUM) || (mode_reg == stt_pkg::MODE_IDENT);

    always_comb
    begin
        case (c)
            "+":     op_k = stt_pkg::TOK_PLUS;
            "-":     op_k = stt_pkg::TOK_MINUS;
            "*":     op_k = stt_pkg::TOK_STAR;
            "/":     op_k = stt_pkg::TOK_SLASH;
            "=":     op_k = stt_pkg::TOK_ASSIGN;
            "&":     op_k = stt_pkg::TOK_AMP;
            "(":     op_k = stt_pkg::TOK_LPAREN;
            ")":     op_k = stt_pkg::TOK_RPAREN;
            "{":     op_k = stt_pkg::TOK_LBRACE;
            "}":     op_k = stt_pkg::TOK_RBRACE;
            ";":     op_k = stt_pkg::TOK_SEMI;
            default: op_k = stt_pkg::TOK_INVALID;
        endcase
    end

    // token closed by this byte
    always_comb
    begin
        run_tok.start  = 32'(run_start_reg);
        run_tok.length = 16'(run_len_reg);
        run_tok.last   = 1'b0;
        if (mode_reg == stt_pkg::MODE_NUM)
        begin
            run_tok.kind  = has_letter_reg ? stt_pkg::TOK_INVALID : stt_pkg::TOK_INT;
            run_tok.cause = has_letter_reg ? stt_pkg::CAUSE_NUM_LETTER
                                           : stt_pkg::CAUSE_NONE;
        end
        else
        begin
            run_tok.kind  = ident_kind(lead_reg, run_len_reg);
            run_tok.cause = stt_pkg::CAUSE_NONE;
        end
    end

    // single-byte token of this byte (eof, operator or stray)
    always_comb
    begin
        byte_tok.start  = 32'(pos_reg);
        byte_tok.length = 16'd1;
        byte_tok.last   = 1'b0;
        byte_tok.cause  = stt_pkg::CAUSE_NONE;
        if (c == 8'd0)
            byte_tok.kind = stt_pkg::TOK_EOF;
        else if (op_k != stt_pkg::TOK_INVALID)
            byte_tok.kind = op_k;
        else
        begin
            byte_tok.kind  = stt_pkg::TOK_INVALID;
            byte_tok.cause = stt_pkg::CAUSE_STRAY;
        end
    end

    always_comb
    begin
        logic byte_emits;
        mode_next       = mode_reg;
        pos_next        = pos_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        has_letter_next = has_letter_reg;
        lead_next       = lead_reg;
        n_res           = 2'd0;
        res0            = byte_tok;
        res1            = byte_tok;
        byte_emits      = !(c_space || c_digit || c_alpha);

        if (in_run && (c_digit || c_alpha))
        begin
            // token continues
            if (mode_reg == stt_pkg::MODE_NUM && c_alpha)
                has_letter_next = 1'b1;
            for (int i = 0; i < stt_pkg::LEAD_BYTES; i++)
            begin
                if (run_len_reg == LW'(i))
                    lead_next[8*i +: 8] = c;
            end
            if (run_len_reg != stt_pkg::LEN_MAX)
                run_len_next = run_len_reg + LW'(1);
            pos_next = pos_reg + PW'(1);
        end
        else
        begin
            mode_next = stt_pkg::MODE_IDLE;
            if (in_run)
            begin
                res0  = run_tok;
                n_res = byte_emits ? 2'd2 : 2'd1;
            end
            else
                n_res = byte_emits ? 2'd1 : 2'd0;

            if (c_digit || c_alpha)
            begin
                mode_next       = c_digit ? stt_pkg::MODE_NUM : stt_pkg::MODE_IDENT;
                run_start_next  = pos_reg;
                run_len_next    = LW'(1);
                has_letter_next = 1'b0;
                lead_next       = DW'(c);
            end
            // eof keeps its position
            if (c != 8'd0)
                pos_next = pos_reg + PW'(1);
        end

        if (n_res == 2'd1)
            res0.last = 1'b1;
        res1.last = 1'b1;
    end

    // result buffer: a byte is taken only when the buffer is empty after this pop
    assign chars.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && tokens.ready);

    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (out_acc)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (in_acc && n_res != 2'd0)
        begin
            slot0_next = res0;
            slot1_next = res1;
            cnt_next   = n_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= stt_pkg::MODE_IDLE;
            pos_reg        <= '0;
            run_start_reg  <= '0;
            run_len_reg    <= '0;
            has_letter_reg <= 1'b0;
            lead_reg       <= '0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (in_acc)
            begin
                mode_reg       <= mode_next;
                pos_reg        <= pos_next;
                run_start_reg  <= run_start_next;
                run_len_reg    <= run_len_next;
                has_letter_reg <= has_letter_next;
                lead_reg       <= lead_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign tokens.valid        = (cnt_reg != 2'd0);
    assign tokens.token_kind   = slot0_reg.kind;
    assign tokens.token_start  = slot0_reg.start;
    assign tokens.token_length = slot0_reg.length;
    assign tokens.error_cause  = slot0_reg.cause;
    assign tokens.last_of_run  = slot0_reg.last;

    `ASSERT_IMPLY(a_accept_room, clk, rst_n, in_acc, (cnt_reg == 2'd0) || out_acc)
    `ASSERT_IMPLY(a_pair_order, clk, rst_n, cnt_reg == 2'd2, slot1_reg.last && !slot0_reg.last)
    `ASSERT_IMPLY(a_run_nonempty, clk, rst_n, mode_reg != stt_pkg::MODE_IDLE, run_len_reg != '0)
    `ASSERT_NEXT(a_eof_holds_pos, clk, rst_n, in_acc && (c == 8'd0), $stable(pos_reg))

endmodule
